[hw/rtl/vpd_pkg.sv]
// Shared types and constants for the VP8 payload descriptor parser.
package vpd_pkg;

	// Bit positions within the descriptor bytes
	localparam int unsigned FlagBit    = 7;  // X on the first byte, I on extension, M on ID
	localparam int unsigned StartBit   = 4;
	localparam int unsigned NonRefBit  = 5;

	localparam int unsigned ByteW      = 8;
	localparam int unsigned PartW      = 3;
	localparam int unsigned BaseW      = 5;
	localparam int unsigned FlagsW     = 2;
	localparam int unsigned PicIdW     = 15;
	localparam int unsigned PicIdLoW   = 7;

	typedef struct packed {
		logic              is_bitstream;
		logic [ByteW-1:0]  stream_byte;
		logic              end_of_payload;
		logic              desc_ok;
		logic [PartW-1:0]  part_idx;
		logic              part_start;
		logic              non_ref;
		logic              pic_id_present;
		logic              pic_id_wide;
		logic [PicIdW-1:0] pic_id;
	} result_t;

endpackage

[hw/rtl/vp8_payload_descriptor_parser_unit.sv]
// Top level of the VP8 RTP payload descriptor parser.
//
// Input channel (in_valid/in_ready): one payload byte per request, with
// final_byte set on the last byte of the payload. Output channel
// (out_valid/out_ready): exactly one result per input byte, in order,
// carrying the byte, its bitstream flag and, on the last byte, the
// decoded descriptor with desc_ok.
//
// The input register takes the byte when it is accepted, and the result
// register then takes the phase decode of that byte and raises out_valid.
// Throughput is one byte per cycle while the receiver does not stall.
//
// Reset clears both stages and returns the parser to expecting the first
// byte of a payload; the last byte of every payload also returns it there.
// When the receiver stalls, the result register holds and the input
// register can still take one more byte; in_ready falls only when both
// are full.
module vp8_payload_descriptor_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [vpd_pkg::ByteW-1:0]  data_byte,
	input  logic                       final_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       is_bitstream,
	output logic [vpd_pkg::ByteW-1:0]  stream_byte,
	output logic                       end_of_payload,
	output logic                       desc_ok,
	output logic [vpd_pkg::PartW-1:0]  part_idx,
	output logic                       part_start,
	output logic                       non_ref,
	output logic                       pic_id_present,
	output logic                       pic_id_wide,
	output logic [vpd_pkg::PicIdW-1:0] pic_id
);
	import vpd_pkg::*;

	logic             valid_s1, final_s1, ready_s2;
	logic [ByteW-1:0] data_s1;
	result_t          res, res_s2;

	vpd_input_stage u_input (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.ready_s2   (ready_s2),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.final_s1   (final_s1)
	);

	vpd_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (valid_s1 && ready_s2),
		.data_s1  (data_s1),
		.final_s1 (final_s1),
		.res      (res)
	);

	vpd_result_stage u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.ready_s2  (ready_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_s2    (res_s2)
	);

	assign is_bitstream   = res_s2.is_bitstream;
	assign stream_byte    = res_s2.stream_byte;
	assign end_of_payload = res_s2.end_of_payload;
	assign desc_ok        = res_s2.desc_ok;
	assign part_idx       = res_s2.part_idx;
	assign part_start     = res_s2.part_start;
	assign non_ref        = res_s2.non_ref;
	assign pic_id_present = res_s2.pic_id_present;
	assign pic_id_wide    = res_s2.pic_id_wide;
	assign pic_id         = res_s2.pic_id;

endmodule

[hw/rtl/vpd_input_stage.sv]
// Input register stage: captures one payload byte request per cycle while in_ready is high.
module vpd_input_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [vpd_pkg::ByteW-1:0] data_byte,
	input  logic                      final_byte,
	input  logic                      ready_s2,
	output logic                      valid_s1,
	output logic [vpd_pkg::ByteW-1:0] data_s1,
	output logic                      final_s1
);
	import vpd_pkg::*;

	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			final_s1 <= final_byte;
		end
	end

endmodule

[hw/rtl/vpd_parse_core.sv]
// Descriptor phase tracking and per-byte result decode.
module vpd_parse_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [vpd_pkg::ByteW-1:0] data_s1,
	input  logic                      final_s1,
	output vpd_pkg::result_t          res
);
	import vpd_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST = 3'd0,
		PH_EXT   = 3'd1,
		PH_PIC   = 3'd2,
		PH_PICLO = 3'd3,
		PH_BODY  = 3'd4
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [BaseW-1:0]    base_q, base_n;
	logic [FlagsW-1:0]   flags_q, flags_n;
	logic [PicIdW-1:0]   pid_q, pid_n;
	logic                ok, is_bs;

	always_comb begin
		base_n  = base_q;
		flags_n = flags_q;
		pid_n   = pid_q;
		phase_n = PH_BODY;
		ok      = 1'b0;
		is_bs   = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				base_n  = {data_s1[NonRefBit], data_s1[StartBit], data_s1[PartW-1:0]};
				flags_n = '0;
				pid_n   = '0;
				if (data_s1[FlagBit]) begin
					phase_n = PH_EXT;
				end else begin
					ok = 1'b1;
				end
			end
			PH_EXT: begin
				if (data_s1[FlagBit]) begin
					flags_n[0] = 1'b1;
					phase_n    = PH_PIC;
				end else begin
					ok = 1'b1;
				end
			end
			PH_PIC: begin
				if (data_s1[FlagBit]) begin
					pid_n   = {data_s1[PicIdLoW-1:0], {ByteW{1'b0}}};
					phase_n = PH_PICLO;
				end else begin
					pid_n = {{(PicIdW-PicIdLoW){1'b0}}, data_s1[PicIdLoW-1:0]};
					ok    = 1'b1;
				end
			end
			PH_PICLO: begin
				pid_n = pid_q | {{(PicIdW-ByteW){1'b0}}, data_s1};
				// a wide ID ending the payload counts as truncated
				if (!final_s1) begin
					flags_n[1] = 1'b1;
				end
			end
			default: begin
				is_bs = 1'b1;
				ok    = 1'b1;
			end
		endcase
	end

	always_comb begin
		res                = '0;
		res.is_bitstream   = is_bs;
		res.stream_byte    = data_s1;
		res.end_of_payload = final_s1;
		if (final_s1) begin
			res.desc_ok        = ok;
			res.part_idx       = base_n[PartW-1:0];
			res.part_start     = base_n[PartW];
			res.non_ref        = base_n[PartW+1];
			res.pic_id_present = flags_n[0];
			res.pic_id_wide    = ok & flags_n[1];
			res.pic_id         = ok ? pid_n : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			base_q  <= '0;
			flags_q <= '0;
			pid_q   <= '0;
		end else if (advance) begin
			if (final_s1) begin
				// drop all descriptor state for the next payload
				phase_q <= PH_FIRST;
				base_q  <= '0;
				flags_q <= '0;
				pid_q   <= '0;
			end else begin
				phase_q <= phase_n;
				base_q  <= base_n;
				flags_q <= flags_n;
				pid_q   <= pid_n;
			end
		end
	end

endmodule

[hw/rtl/vpd_result_stage.sv]
// Result register stage: holds a finished result until the receiver takes it.
module vpd_result_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  vpd_pkg::result_t res,
	output logic             ready_s2,
	output logic             out_valid,
	input  logic             out_ready,
	output vpd_pkg::result_t res_s2
);
	import vpd_pkg::*;

	assign ready_s2 = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule
